/* design/scan_sweep_peak_controller_unit_defines.svh */
// Assertion macros for the scan sweep peak controller.
`ifndef SCAN_SWEEP_PEAK_CONTROLLER_UNIT_DEFINES_SVH
`define SCAN_SWEEP_PEAK_CONTROLLER_UNIT_DEFINES_SVH

`ifndef SYNTHESIS
`define SSPC_ASSERT_IMPL(label, ante, cons, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error(msg);
`define SSPC_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error(msg);
`else
`define SSPC_ASSERT_IMPL(label, ante, cons, msg)
`define SSPC_ASSERT_NEXT(label, ante, cons, msg)
`endif

`endif

/* design/sspc_pkg.sv */
// Types and constants shared by the scan sweep peak controller.
package sspc_pkg;

    localparam int FREQ_W  = 32;
    localparam int TIME_W  = 32;
    localparam int STR_W   = 16;
    localparam int CNT_W   = 16;
    localparam int PAUSE_W = 16;
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 32;

    typedef enum logic [1:0] {
        MODE_SEARCHING = 2'd0,
        MODE_PEAKING   = 2'd1,
        MODE_EXITING   = 2'd2
    } t_mode;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_MIN_FREQ      = 3'd0,
        CFG_MAX_FREQ      = 3'd1,
        CFG_STEP_SIZE     = 3'd2,
        CFG_SQUELCH_LEVEL = 3'd3,
        CFG_PAUSE_TIME    = 3'd4,
        CFG_SAVE_ENABLE   = 3'd5
    } t_cfg_idx;

    localparam logic [CNT_W-1:0] CNT_MAX = '1;

endpackage

/* design/scan_sweep_peak_controller_unit.sv */
// Scan sweep peak controller: one input register, single-pass step logic, one result register.
//
// The block takes one item per clock cycle while the result register is free or being read: the
// item is captured in an input register, the whole search, peak and exit decision with the wrapped
// frequency step is evaluated in one combinational pass, and the result is held in an output
// register. A stalled output holds at most one further item in the input register; configuration
// writes are always ready and take effect at once.
`include "scan_sweep_peak_controller_unit_defines.svh"

module scan_sweep_peak_controller_unit
    import sspc_pkg::*;
(
    input  logic                         i_clk,
    input  logic                         i_rst_n,

    input  logic                         i_cfg_valid,
    output logic                         o_cfg_ready,
    input  logic [CFG_IDX_W-1:0]         i_cfg_index,
    input  logic [CFG_DATA_W-1:0]        i_cfg_data,

    input  logic                         i_in_valid,
    output logic                         o_in_ready,
    input  logic                         i_op,
    input  logic [TIME_W-1:0]            i_now_ms,
    input  logic [FREQ_W-1:0]            i_current_freq,
    input  logic signed [STR_W-1:0]      i_strength,

    output logic                         o_out_valid,
    input  logic                         i_out_ready,
    output logic                         o_tune_valid,
    output logic [FREQ_W-1:0]            o_new_freq,
    output logic                         o_save_strobe,
    output logic [CNT_W-1:0]             o_save_index,
    output logic [FREQ_W-1:0]            o_peak_freq,
    output logic                         o_stopped_event,
    output logic                         o_running,
    output logic [1:0]                   o_scan_mode
);

    logic [FREQ_W-1:0]          r_min_freq;
    logic [FREQ_W-1:0]          r_max_freq;
    logic [FREQ_W-1:0]          r_step_size;
    logic signed [STR_W-1:0]    r_squelch_level;
    logic [PAUSE_W-1:0]         r_pause_time;
    logic                       r_save_enable;

    logic                       r_in_valid;
    logic                       r_op;
    logic [TIME_W-1:0]          r_now_ms;
    logic [FREQ_W-1:0]          r_current_freq;
    logic signed [STR_W-1:0]    r_strength;

    t_mode                      r_mode, n_mode;
    logic                       r_run, n_run;
    logic                       r_back, n_back;
    logic signed [STR_W-1:0]    r_last_str, n_last_str;
    logic [TIME_W-1:0]          r_pause_start, n_pause_start;
    logic                       r_pause_active, n_pause_active;
    logic [FREQ_W-1:0]          r_last_peak, n_last_peak;
    logic [CNT_W-1:0]           r_saved, n_saved;

    logic                       r_out_valid;
    logic                       r_tune, n_tune;
    logic [FREQ_W-1:0]          r_new_freq, n_new_freq;
    logic                       r_strobe, n_strobe;
    logic [CNT_W-1:0]           r_sidx, n_sidx;
    logic [FREQ_W-1:0]          r_peak_freq, n_peak_freq;
    logic                       r_stopped, n_stopped;
    logic                       r_running;
    t_mode                      r_out_mode;

    logic                       w_advance;
    logic                       w_enabled;
    logic                       w_active;
    logic                       w_dir;
    logic [TIME_W-1:0]          w_elapsed;
    logic [FREQ_W-1:0]          w_dist;
    logic [FREQ_W:0]            w_step2;
    logic [FREQ_W-1:0]          w_up;
    logic [FREQ_W-1:0]          w_down;
    logic [FREQ_W-1:0]          w_sum;
    logic [FREQ_W-1:0]          w_next;

    assign o_cfg_ready = 1'b1;
    assign w_advance   = r_in_valid && (!r_out_valid || i_out_ready);
    assign o_in_ready  = !r_in_valid || w_advance;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_min_freq      <= '0;
            r_max_freq      <= '0;
            r_step_size     <= FREQ_W'(1);
            r_squelch_level <= '0;
            r_pause_time    <= '0;
            r_save_enable   <= 1'b0;
        end else if (i_cfg_valid) begin
            unique case (i_cfg_index)
                CFG_MIN_FREQ:      r_min_freq      <= i_cfg_data[FREQ_W-1:0];
                CFG_MAX_FREQ:      r_max_freq      <= i_cfg_data[FREQ_W-1:0];
                CFG_STEP_SIZE:     r_step_size     <= i_cfg_data[FREQ_W-1:0];
                CFG_SQUELCH_LEVEL: r_squelch_level <= i_cfg_data[STR_W-1:0];
                CFG_PAUSE_TIME:    r_pause_time    <= i_cfg_data[PAUSE_W-1:0];
                CFG_SAVE_ENABLE:   r_save_enable   <= i_cfg_data[0];
                default: ;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (o_in_ready) begin
            r_in_valid <= i_in_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_in_ready && i_in_valid) begin
            r_op           <= i_op;
            r_now_ms       <= i_now_ms;
            r_current_freq <= i_current_freq;
            r_strength     <= i_strength;
        end
    end

    assign w_enabled = (r_min_freq != '0);
    assign w_elapsed = r_now_ms - r_pause_start;
    assign w_active  = w_enabled && r_run &&
                       (!r_pause_active || (w_elapsed > TIME_W'(r_pause_time)));
    assign w_dist    = (r_last_peak >= r_current_freq) ? (r_last_peak - r_current_freq)
                                                       : (r_current_freq - r_last_peak);
    assign w_step2   = {r_step_size, 1'b0};
    assign w_up      = r_current_freq + r_step_size;
    assign w_down    = r_current_freq - r_step_size;
    assign w_sum     = w_dir ? w_down : w_up;
    assign w_next    = (w_sum > r_max_freq) ? r_min_freq :
                       (w_sum < r_min_freq) ? r_max_freq : w_sum;

    always_comb begin
        n_mode         = r_mode;
        n_run          = r_run;
        n_back         = r_back;
        n_last_str     = r_last_str;
        n_pause_start  = r_pause_start;
        n_pause_active = r_pause_active;
        n_last_peak    = r_last_peak;
        n_saved        = r_saved;
        n_tune         = 1'b0;
        n_new_freq     = '0;
        n_strobe       = 1'b0;
        n_sidx         = '0;
        n_peak_freq    = '0;
        n_stopped      = 1'b0;
        w_dir          = r_back;
        if (r_op) begin
            if (w_enabled) begin
                if (r_run && !r_back) begin
                    n_back = 1'b1;
                end else if (r_run) begin
                    n_run     = 1'b0;
                    n_mode    = MODE_EXITING;
                    n_stopped = 1'b1;
                    n_saved   = '0;
                end else begin
                    n_run  = 1'b1;
                    n_back = 1'b0;
                end
            end
        end else if (w_active) begin
            n_pause_active = 1'b0;
            unique case (r_mode)
                MODE_PEAKING: begin
                    if (r_strength < r_last_str) begin
                        w_dir = !r_back;
                        if (r_pause_time != '0) begin
                            n_pause_start  = r_now_ms;
                            n_pause_active = 1'b1;
                            n_last_peak    = r_current_freq;
                            n_mode         = MODE_EXITING;
                            if (r_save_enable) begin
                                n_strobe    = 1'b1;
                                n_sidx      = r_saved;
                                n_peak_freq = r_current_freq;
                                if (r_saved != CNT_MAX) begin
                                    n_saved = r_saved + CNT_W'(1);
                                end
                            end
                        end else begin
                            n_run     = 1'b0;
                            n_mode    = MODE_EXITING;
                            n_stopped = 1'b1;
                            n_saved   = '0;
                        end
                    end
                end
                MODE_EXITING: begin
                    if ({1'b0, w_dist} > w_step2) begin
                        n_mode      = MODE_SEARCHING;
                        n_last_peak = '0;
                    end
                end
                MODE_SEARCHING: begin
                    if (r_strength >= r_squelch_level) begin
                        n_mode = MODE_PEAKING;
                    end
                end
                default: ;
            endcase
            n_last_str = r_strength;
            n_tune     = 1'b1;
            n_new_freq = w_next;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mode         <= MODE_EXITING;
            r_run          <= 1'b0;
            r_back         <= 1'b0;
            r_last_str     <= '0;
            r_pause_start  <= '0;
            r_pause_active <= 1'b0;
            r_last_peak    <= '0;
            r_saved        <= '0;
        end else if (w_advance) begin
            r_mode         <= n_mode;
            r_run          <= n_run;
            r_back         <= n_back;
            r_last_str     <= n_last_str;
            r_pause_start  <= n_pause_start;
            r_pause_active <= n_pause_active;
            r_last_peak    <= n_last_peak;
            r_saved        <= n_saved;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (w_advance) begin
            r_out_valid <= 1'b1;
        end else if (i_out_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_advance) begin
            r_tune      <= n_tune;
            r_new_freq  <= n_new_freq;
            r_strobe    <= n_strobe;
            r_sidx      <= n_sidx;
            r_peak_freq <= n_peak_freq;
            r_stopped   <= n_stopped;
            r_running   <= n_run;
            r_out_mode  <= n_mode;
        end
    end

    assign o_out_valid     = r_out_valid;
    assign o_tune_valid    = r_tune;
    assign o_new_freq      = r_new_freq;
    assign o_save_strobe   = r_strobe;
    assign o_save_index    = r_sidx;
    assign o_peak_freq     = r_peak_freq;
    assign o_stopped_event = r_stopped;
    assign o_running       = r_running;
    assign o_scan_mode     = r_out_mode;

    `SSPC_ASSERT_IMPL(a_save_on_pause, o_out_valid && o_save_strobe,
        o_tune_valid && o_running && (o_scan_mode == MODE_EXITING),
        "Save item without an active pause step.")
    `SSPC_ASSERT_IMPL(a_stop_state, o_out_valid && o_stopped_event,
        !o_running && (o_scan_mode == MODE_EXITING),
        "Stop item while the scan still reports running.")
    `SSPC_ASSERT_IMPL(a_idle_clean, o_out_valid && !o_tune_valid,
        (o_new_freq == '0) && !o_save_strobe,
        "Item without tuning carries a frequency or a save.")
    `SSPC_ASSERT_NEXT(a_result_after_step, w_advance, r_out_valid,
        "Processed item did not reach the result register.")

endmodule
